@@ hdl/mce_pkg.sv @@
// Morse character encoder package: interval kinds, controller states and
// the character-to-code lookup. No dependencies.
`default_nettype none

package mce_pkg;

	// Widths of the external and internal fields
	localparam int CHAR_W  = 8;
	localparam int DIT_W   = 10;
	localparam int UNITS_W = 3;
	localparam int TICKS_W = 12;
	localparam int CODE_W  = 8;
	localparam int CNT_W   = 3;

	localparam logic [DIT_W-1:0] DIT_RESET = 10'd92;

	// Interval lengths in dit units
	localparam logic [UNITS_W-1:0] UNITS_DIT   = 3'd1;
	localparam logic [UNITS_W-1:0] UNITS_DAH   = 3'd3;
	localparam logic [UNITS_W-1:0] UNITS_GAP   = 3'd2;
	localparam logic [UNITS_W-1:0] UNITS_SPACE = 3'd4;

	// Characters handled outside the code tables
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;

	// Kind of interval currently presented
	typedef enum logic [1:0] {
		KIND_DOWN  = 2'd0,
		KIND_UP    = 2'd1,
		KIND_GAP   = 2'd2,
		KIND_SPACE = 2'd3
	} kind_t;

	// Controller states, one-hot
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DOWN  = 5'b00010,
		ST_UP    = 5'b00100,
		ST_GAP   = 5'b01000,
		ST_SPACE = 5'b10000
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic  load;
		logic  shift;
		kind_t kind;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_space;
		logic is_known;
		logic last_elem;
	} stat_t;

	// Letter codes A..Z with leading marker bit
	localparam logic [CODE_W-1:0] LETTER_CODES [26] = '{
		8'h05, 8'h18, 8'h1A, 8'h0C, 8'h02, 8'h12, 8'h0E, 8'h10, 8'h04, 8'h17,
		8'h0D, 8'h14, 8'h07, 8'h06, 8'h0F, 8'h16, 8'h1D, 8'h0A, 8'h08, 8'h03,
		8'h09, 8'h11, 8'h0B, 8'h19, 8'h1B, 8'h1C
	};

	// Digit codes 0..9
	localparam logic [CODE_W-1:0] DIGIT_CODES [10] = '{
		8'h3F, 8'h2F, 8'h27, 8'h23, 8'h21, 8'h20, 8'h30, 8'h38, 8'h3C, 8'h3E
	};

	// Return the marked code of a character, zero when it has none
	function automatic logic [CODE_W-1:0] lookup_code(input logic [CHAR_W-1:0] ch);
		logic [CHAR_W-1:0] up;
		logic [CODE_W-1:0] code;
		up = ch;
		if (ch >= 8'h61 && ch <= 8'h7A) begin
			up = ch - 8'd32;
		end
		code = '0;
		if (up >= 8'h41 && up <= 8'h5A) begin
			code = LETTER_CODES[5'(up - 8'h41)];
		end else if (up >= 8'h30 && up <= 8'h39) begin
			code = DIGIT_CODES[4'(up - 8'h30)];
		end else begin
			unique case (up)
				8'h2E:   code = 8'h55; // period
				8'h2C:   code = 8'h73; // comma
				8'h21:   code = 8'h6B; // exclamation
				8'h3F:   code = 8'h4C; // question
				8'h2F:   code = 8'h32; // slash
				8'h2B:   code = 8'h2A; // plus
				8'h2D:   code = 8'h61; // minus
				8'h3D:   code = 8'h31; // equals
				8'h40:   code = 8'h5A; // at sign
				default: code = '0;
			endcase
		end
		return code;
	endfunction

endpackage

`default_nettype wire

@@ hdl/morse_character_encoder.sv @@
// Morse character encoder top level: joins controller and datapath.
// Depends on mce_pkg, mce_ctrl and mce_dp.
`default_nettype none

// Takes one ASCII character per transaction and returns its Morse keying as
// a run of interval transactions (key_down, length_units, length_ticks, last).
// Letters of either case, digits and . , ! ? / + - = @ give one key-down
// interval per element (dit 1 unit, dah 3 units), each followed by a 1-unit
// key-up, then a closing 2-unit key-up flagged last. Space, CR and LF give a
// single 4-unit key-up flagged last; any other byte gives nothing. The
// controller steps one interval per cycle while out_stall is low, so a
// character gives 2N+1 intervals (up to 13) for N elements (up to 6), or
// one for a word space. The next character is taken in the cycle its
// predecessor's last interval is delivered. dit_length (reset 92 ticks)
// is written via dit_length_we, by users only while idle (not enforced).
module morse_character_encoder (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          dit_length_we,
	input  wire  [mce_pkg::DIT_W-1:0]    dit_length,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  [mce_pkg::CHAR_W-1:0]   character,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic                         key_down,
	output logic [mce_pkg::UNITS_W-1:0]  length_units,
	output logic [mce_pkg::TICKS_W-1:0]  length_ticks,
	output logic                         last
);
	import mce_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequence the intervals
	mce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Hold code, count and dit length; form fields
	mce_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.character     (character),
		.dit_length_we (dit_length_we),
		.dit_length    (dit_length),
		.cmd           (cmd),
		.stat          (stat),
		.key_down      (key_down),
		.length_units  (length_units),
		.length_ticks  (length_ticks),
		.last          (last)
	);

endmodule

`default_nettype wire

@@ hdl/mce_ctrl.sv @@
// Morse encoder controller: walks the intervals of one character.
// Depends on mce_pkg for states, command and status types.
`default_nettype none

module mce_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  wire            out_stall,
	input  mce_pkg::stat_t stat,
	output mce_pkg::cmd_t  cmd
);
	import mce_pkg::*;

	state_t state_q;
	state_t state_d;
	state_t from_char;
	logic   accept;
	logic   take;

	// Handshakes: take a new character when idle or as the closing interval leaves
	assign out_valid = (state_q != ST_IDLE);
	assign take      = out_valid && !out_stall;
	assign in_stall  = !((state_q == ST_IDLE) ||
		(((state_q == ST_GAP) || (state_q == ST_SPACE)) && !out_stall));
	assign accept    = in_valid && !in_stall;

	// Pick the first state for an incoming character
	always_comb begin
		priority if (stat.is_space) begin
			from_char = ST_SPACE;
		end else if (stat.is_known) begin
			from_char = ST_DOWN;
		end else begin
			from_char = ST_IDLE;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d   = state_q;
		cmd.load  = accept;
		cmd.shift = 1'b0;
		cmd.kind  = KIND_UP;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = from_char;
			end
			ST_DOWN: begin
				cmd.kind = KIND_DOWN;
				if (take) state_d = ST_UP;
			end
			ST_UP: begin
				cmd.kind = KIND_UP;
				if (take) begin
					cmd.shift = 1'b1;
					state_d   = stat.last_elem ? ST_GAP : ST_DOWN;
				end
			end
			ST_GAP: begin
				cmd.kind = KIND_GAP;
				if (take) state_d = accept ? from_char : ST_IDLE;
			end
			ST_SPACE: begin
				cmd.kind = KIND_SPACE;
				if (take) state_d = accept ? from_char : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ hdl/mce_dp.sv @@
// Morse encoder datapath: code lookup, element shift register, dit length
// register and interval fields. Depends on mce_pkg.
`default_nettype none

module mce_dp (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire  [mce_pkg::CHAR_W-1:0]     character,
	input  wire                            dit_length_we,
	input  wire  [mce_pkg::DIT_W-1:0]      dit_length,
	input  mce_pkg::cmd_t                  cmd,
	output mce_pkg::stat_t                 stat,
	output logic                           key_down,
	output logic [mce_pkg::UNITS_W-1:0]    length_units,
	output logic [mce_pkg::TICKS_W-1:0]    length_ticks,
	output logic                           last
);
	import mce_pkg::*;

	logic [DIT_W-1:0]  dit_q;
	logic [CODE_W-2:0] sh_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CODE_W-1:0] code;
	logic [CNT_W-1:0]  top;

	// Look up the incoming character and find its marker bit
	assign code = lookup_code(character);
	always_comb begin
		top = '0;
		for (int i = 1; i < CODE_W; i++) begin
			if (code[i]) top = CNT_W'(i);
		end
	end

	assign stat.is_space  = (character == CH_SPACE) || (character == CH_CR) ||
		(character == CH_LF);
	assign stat.is_known  = (code != '0);
	assign stat.last_elem = (cnt_q == CNT_W'(1));

	// Dit length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dit_q <= DIT_RESET;
		end else if (dit_length_we) begin
			dit_q <= dit_length;
		end
	end

	// Load the elements left-aligned, advance one element per key-up
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sh_q  <= code[CODE_W-2:0] << (CNT_W'(CODE_W - 1) - top);
			cnt_q <= top;
		end else if (cmd.shift) begin
			sh_q  <= sh_q << 1;
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Form the interval fields
	always_comb begin
		unique case (cmd.kind)
			KIND_DOWN: begin
				key_down     = 1'b1;
				length_units = sh_q[CODE_W-2] ? UNITS_DAH : UNITS_DIT;
				last         = 1'b0;
			end
			KIND_UP: begin
				key_down     = 1'b0;
				length_units = UNITS_DIT;
				last         = 1'b0;
			end
			KIND_GAP: begin
				key_down     = 1'b0;
				length_units = UNITS_GAP;
				last         = 1'b1;
			end
			KIND_SPACE: begin
				key_down     = 1'b0;
				length_units = UNITS_SPACE;
				last         = 1'b1;
			end
			default: begin
				key_down     = 1'b0;
				length_units = UNITS_DIT;
				last         = 1'b0;
			end
		endcase
	end

	// Units times dit length
	assign length_ticks = TICKS_W'(TICKS_W'(length_units) * TICKS_W'(dit_q));

endmodule

`default_nettype wire
